/* rtl/gcf_pkg.sv */
// ----------------------------------------------------------------------------
// gcf_pkg: shared constants and types of the grouped class FIFO
// Sizes, field widths, command and status codes, controller command bundle.
// ----------------------------------------------------------------------------
package gcf_pkg;

	// sizing
	localparam int NUM_CLASSES = 4;
	localparam int CLASS_DEPTH = 16;
	localparam int VALUE_BITS  = 16;

	// request and response field widths
	localparam int CMD_W      = 1;
	localparam int CLASS_ID_W = 3;
	localparam int STATUS_W   = 2;

	// derived widths
	localparam int CLS_W     = $clog2(NUM_CLASSES);
	localparam int SLOT_W    = $clog2(CLASS_DEPTH);
	localparam int CNT_W     = $clog2(CLASS_DEPTH + 1);
	localparam int OCNT_W    = $clog2(NUM_CLASSES + 1);
	localparam int MEM_DEPTH = NUM_CLASSES * CLASS_DEPTH;
	localparam int ADDR_W    = $clog2(MEM_DEPTH);

	// command codes
	localparam logic [CMD_W-1:0] CMD_ENQ = 1'b0;
	localparam logic [CMD_W-1:0] CMD_DEQ = 1'b1;

	// status codes
	localparam logic [STATUS_W-1:0] ST_ENQ     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_SERVED  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd2;
	localparam logic [STATUS_W-1:0] ST_DROPPED = 2'd3;

	// controller to datapath commands
	typedef struct packed {
		logic load;   // capture the accepted request
		logic exec;   // apply the request to the queue state
	} gcf_cmd_t;

endpackage

/* rtl/gcf_req_if.sv */
// ----------------------------------------------------------------------------
// gcf_req_if: request channel
// Valid/ready channel carrying one enqueue or dequeue request.
// ----------------------------------------------------------------------------
interface gcf_req_if;
	logic                              valid;
	logic                              ready;
	logic [gcf_pkg::CMD_W-1:0]         cmd;
	logic [gcf_pkg::CLASS_ID_W-1:0]    class_id;
	logic [gcf_pkg::VALUE_BITS-1:0]    value;

	modport source (output valid, output cmd, output class_id, output value, input ready);
	modport sink   (input valid, input cmd, input class_id, input value, output ready);
endinterface

/* rtl/gcf_rsp_if.sv */
// ----------------------------------------------------------------------------
// gcf_rsp_if: response channel
// Valid/ready channel carrying the status and served value of one request.
// ----------------------------------------------------------------------------
interface gcf_rsp_if;
	logic                              valid;
	logic                              ready;
	logic [gcf_pkg::STATUS_W-1:0]      status;
	logic [gcf_pkg::CLASS_ID_W-1:0]    served_class;
	logic [gcf_pkg::VALUE_BITS-1:0]    served_value;

	modport source (output valid, output status, output served_class, output served_value,
		input ready);
	modport sink   (input valid, input status, input served_class, input served_value,
		output ready);
endinterface

/* rtl/grouped_class_fifo.sv */
// ----------------------------------------------------------------------------
// grouped_class_fifo: team queue of values grouped by class
// Per-class FIFOs served in the order in which classes became non-empty.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one request: cmd enqueue (class_id, value) or dequeue.
//   rsp returns exactly one response per request: status enqueued, served,
//   dequeue on empty, or dropped (class full or class_id out of 1..4), with
//   served_class / served_value set on a served dequeue and zero otherwise.
//   Requests are taken one at a time. A request is accepted in the idle
//   cycle, applied to the queue state in the next cycle (the single value
//   memory port is written or read there), and its response is valid in
//   the cycle after.
//   The block takes no new request until the response has been taken, so a
//   stalled receiver holds the response stable and back-pressures req.
//   Reset clears all pointers and counts, including the head and count of
//   the class order ring; the ring entries and the value memory need no
//   clearing since counts guard every read. The block is ready for a
//   request in the first cycle after reset.
module grouped_class_fifo (
	input  logic       clk,
	input  logic       arst_n,
	gcf_req_if.sink    req,
	gcf_rsp_if.source  rsp
);

	gcf_pkg::gcf_cmd_t cmd;

	// sequence one request at a time
	gcf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd)
	);

	// queue state, order ring and value memory
	gcf_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.req_cmd      (req.cmd),
		.req_class_id (req.class_id),
		.req_value    (req.value),
		.status       (rsp.status),
		.served_class (rsp.served_class),
		.served_value (rsp.served_value)
	);

endmodule

/* rtl/gcf_ctrl.sv */
// ----------------------------------------------------------------------------
// gcf_ctrl: request sequencer
// Accepts one request, runs it through the datapath, holds the response.
// ----------------------------------------------------------------------------
module gcf_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output gcf_pkg::gcf_cmd_t cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_RESP
	} state_t;

	state_t state_q;
	logic   req_ready_q;
	logic   rsp_valid_q;

	assign req_ready = req_ready_q;
	assign rsp_valid = rsp_valid_q;
	assign cmd.load  = req_valid && req_ready_q;
	assign cmd.exec  = (state_q == S_EXEC);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			req_ready_q <= 1'b1;
			rsp_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						state_q     <= S_EXEC;
						req_ready_q <= 1'b0;
					end
				end
				S_EXEC: begin
					state_q     <= S_RESP;
					rsp_valid_q <= 1'b1;
				end
				S_RESP: begin
					// hold the response until taken
					if (rsp_ready) begin
						state_q     <= S_IDLE;
						rsp_valid_q <= 1'b0;
						req_ready_q <= 1'b1;
					end
				end
				default: begin
					state_q     <= S_IDLE;
					req_ready_q <= 1'b1;
					rsp_valid_q <= 1'b0;
				end
			endcase
		end
	end

endmodule

/* rtl/gcf_dp.sv */
// ----------------------------------------------------------------------------
// gcf_dp: queue datapath
// Per-class FIFO pointers and counts, class order ring, value memory.
// ----------------------------------------------------------------------------
module gcf_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  gcf_pkg::gcf_cmd_t                   cmd,
	input  logic [gcf_pkg::CMD_W-1:0]           req_cmd,
	input  logic [gcf_pkg::CLASS_ID_W-1:0]      req_class_id,
	input  logic [gcf_pkg::VALUE_BITS-1:0]      req_value,
	output logic [gcf_pkg::STATUS_W-1:0]        status,
	output logic [gcf_pkg::CLASS_ID_W-1:0]      served_class,
	output logic [gcf_pkg::VALUE_BITS-1:0]      served_value
);

	localparam int N  = gcf_pkg::NUM_CLASSES;
	localparam int SW = gcf_pkg::SLOT_W;
	localparam int CW = gcf_pkg::CNT_W;
	localparam int KW = gcf_pkg::CLS_W;
	localparam int OW = gcf_pkg::OCNT_W;
	localparam int AW = gcf_pkg::ADDR_W;
	localparam int IW = gcf_pkg::CLASS_ID_W;

	function automatic logic [SW-1:0] slot_next(input logic [SW-1:0] s);
		return (s == SW'(gcf_pkg::CLASS_DEPTH - 1)) ? '0 : s + SW'(1);
	endfunction

	function automatic logic [KW-1:0] ring_next(input logic [KW-1:0] p);
		return (p == KW'(N - 1)) ? '0 : p + KW'(1);
	endfunction

	// captured request
	logic [gcf_pkg::CMD_W-1:0]      cmd_q;
	logic [IW-1:0]                  cls_q;
	logic [gcf_pkg::VALUE_BITS-1:0] val_q;

	// queue state
	logic [SW-1:0] head_q   [N];
	logic [SW-1:0] tail_q   [N];
	logic [CW-1:0] count_q  [N];
	logic [KW-1:0] ring_q   [N];
	logic [KW-1:0] ohead_q;
	logic [OW-1:0] ocount_q;

	logic [gcf_pkg::VALUE_BITS-1:0] mem_q [gcf_pkg::MEM_DEPTH];
	logic [gcf_pkg::VALUE_BITS-1:0] rd_q;

	// result
	logic [gcf_pkg::STATUS_W-1:0] status_q;
	logic [IW-1:0]                sclass_q;
	logic                         served_q;

	// decode
	logic          is_enq;
	logic          cls_ok;
	logic [KW-1:0] ek;
	logic [KW-1:0] dk;
	logic          enq_ok;
	logic          deq_ok;
	logic          enq_first;
	logic [OW:0]   ins_sum;
	logic [KW-1:0] ins_pos;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] rd_addr;
	logic [gcf_pkg::STATUS_W-1:0] status_d;
	logic [IW-1:0]                sclass_d;

	always_comb begin
		is_enq    = (cmd_q == gcf_pkg::CMD_ENQ);
		cls_ok    = (cls_q != '0) && (cls_q <= IW'(N));
		ek        = KW'(cls_q - IW'(1));
		dk        = ring_q[ohead_q];
		enq_ok    = is_enq && cls_ok && (count_q[ek] != CW'(gcf_pkg::CLASS_DEPTH));
		deq_ok    = !is_enq && (ocount_q != '0);
		enq_first = (count_q[ek] == '0) && (ocount_q < OW'(N));
		ins_sum   = (OW + 1)'(ohead_q) + (OW + 1)'(ocount_q);
		ins_pos   = (ins_sum >= (OW + 1)'(N)) ? KW'(ins_sum - (OW + 1)'(N)) : KW'(ins_sum);
		wr_addr   = AW'(ek) * AW'(gcf_pkg::CLASS_DEPTH) + AW'(tail_q[ek]);
		rd_addr   = AW'(dk) * AW'(gcf_pkg::CLASS_DEPTH) + AW'(head_q[dk]);
		if (is_enq) begin
			status_d = enq_ok ? gcf_pkg::ST_ENQ : gcf_pkg::ST_DROPPED;
		end else begin
			status_d = deq_ok ? gcf_pkg::ST_SERVED : gcf_pkg::ST_EMPTY;
		end
		sclass_d = deq_ok ? IW'(dk) + IW'(1) : '0;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < N; i++) begin
				head_q[i]  <= '0;
				tail_q[i]  <= '0;
				count_q[i] <= '0;
			end
			ohead_q  <= '0;
			ocount_q <= '0;
		end else if (cmd.exec) begin
			if (enq_ok) begin
				tail_q[ek]  <= slot_next(tail_q[ek]);
				count_q[ek] <= count_q[ek] + CW'(1);
				if (enq_first) begin
					ocount_q <= ocount_q + OW'(1);
				end
			end
			if (deq_ok) begin
				head_q[dk] <= slot_next(head_q[dk]);
				if (count_q[dk] != '0) begin
					count_q[dk] <= count_q[dk] - CW'(1);
				end
				// class runs dry: drop it from the order ring
				if (count_q[dk] <= CW'(1)) begin
					ohead_q  <= ring_next(ohead_q);
					ocount_q <= ocount_q - OW'(1);
				end
			end
		end
	end

	// payload, ring entries and value memory
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q <= req_cmd;
			cls_q <= req_class_id;
			val_q <= req_value;
		end
		if (cmd.exec) begin
			status_q <= status_d;
			sclass_q <= sclass_d;
			served_q <= deq_ok;
			if (enq_ok) begin
				mem_q[wr_addr] <= val_q;
				if (enq_first) begin
					ring_q[ins_pos] <= ek;
				end
			end
			if (deq_ok) begin
				rd_q <= mem_q[rd_addr];
			end
		end
	end

	assign status       = status_q;
	assign served_class = sclass_q;
	assign served_value = served_q ? rd_q : '0;

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench of grouped_class_fifo
// Drives enqueue and dequeue requests through the request channel, predicts
// each response with a cycle-free model of the class queues and the class
// order ring, and compares every response field by field. Directed requests
// cover dequeue on empty, out-of-range classes, service order and a full
// class. Random traffic with shifting enqueue bias then fills and drains the
// classes under three mixes of sender idling and receiver stalls.
// ----------------------------------------------------------------------------
module tb;

	localparam int CYCLE_LIMIT = 200000;
	localparam int MAX_SHOWN   = 10;

	typedef struct packed {
		logic [gcf_pkg::STATUS_W-1:0]   status;
		logic [gcf_pkg::CLASS_ID_W-1:0] served_class;
		logic [gcf_pkg::VALUE_BITS-1:0] served_value;
	} rsp_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	gcf_req_if req_ch ();
	gcf_rsp_if rsp_ch ();

	grouped_class_fifo dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always #5 clk = ~clk;

	// Predicted queue state: per-class value rings, their read and write
	// slots and fill levels, plus the ring of classes in service order.
	logic [gcf_pkg::VALUE_BITS-1:0] class_mem [gcf_pkg::NUM_CLASSES][gcf_pkg::CLASS_DEPTH];
	logic [gcf_pkg::SLOT_W-1:0]     rd_slot   [gcf_pkg::NUM_CLASSES];
	logic [gcf_pkg::SLOT_W-1:0]     wr_slot   [gcf_pkg::NUM_CLASSES];
	logic [gcf_pkg::CNT_W-1:0]      fill      [gcf_pkg::NUM_CLASSES];
	logic [gcf_pkg::CLS_W-1:0]      turn_ring [gcf_pkg::NUM_CLASSES];
	logic [gcf_pkg::CLS_W-1:0]      turn_head;
	logic [gcf_pkg::OCNT_W-1:0]     turn_count;

	// Responses owed by the block, oldest first.
	rsp_t expected_rsp [$];

	int mismatches;
	int requests_taken;
	int n_enqueued;
	int n_served;
	int n_empty;
	int n_dropped;
	int cycle_count;

	// Idle mix, changed between phases.
	int send_idle_pct;
	int stall_pct;

	// Apply one request to the predicted state and return its response.
	function automatic rsp_t predict_request(input logic [gcf_pkg::CMD_W-1:0] op,
		input logic [gcf_pkg::CLASS_ID_W-1:0] cid,
		input logic [gcf_pkg::VALUE_BITS-1:0] val);
		rsp_t r;
		int   k;
		r = '0;
		if (op == gcf_pkg::CMD_ENQ) begin
			if (cid == 0 || cid > gcf_pkg::NUM_CLASSES) begin
				r.status = gcf_pkg::ST_DROPPED;
			end else begin
				k = int'(cid) - 1;
				if (fill[k] >= gcf_pkg::CLASS_DEPTH) begin
					r.status = gcf_pkg::ST_DROPPED;
				end else begin
					class_mem[k][wr_slot[k]] = val;
					wr_slot[k] = (wr_slot[k] == gcf_pkg::CLASS_DEPTH - 1) ? '0 :
						wr_slot[k] + 1'b1;
					// an empty class joins the back of the service order
					if (fill[k] == 0 && turn_count < gcf_pkg::NUM_CLASSES) begin
						turn_ring[(int'(turn_head) + int'(turn_count)) % gcf_pkg::NUM_CLASSES] =
							k[gcf_pkg::CLS_W-1:0];
						turn_count = turn_count + 1'b1;
					end
					fill[k] = fill[k] + 1'b1;
					r.status = gcf_pkg::ST_ENQ;
				end
			end
		end else if (turn_count == 0) begin
			r.status = gcf_pkg::ST_EMPTY;
		end else begin
			k = int'(turn_ring[turn_head]);
			r.status       = gcf_pkg::ST_SERVED;
			r.served_class = gcf_pkg::CLASS_ID_W'(k + 1);
			r.served_value = class_mem[k][rd_slot[k]];
			rd_slot[k] = (rd_slot[k] == gcf_pkg::CLASS_DEPTH - 1) ? '0 : rd_slot[k] + 1'b1;
			if (fill[k] > 0)
				fill[k] = fill[k] - 1'b1;
			// a drained class leaves the front of the service order
			if (fill[k] == 0) begin
				turn_head  = gcf_pkg::CLS_W'((int'(turn_head) + 1) % gcf_pkg::NUM_CLASSES);
				turn_count = turn_count - 1'b1;
			end
		end
		return r;
	endfunction

	// Receiver: stall at random, redrawn at every falling edge.
	always @(negedge clk) begin
		rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
	end

	// Predict on every accepted request, check every accepted response.
	// Prediction goes first so the queue order holds even if both happen
	// at the same edge.
	always @(posedge clk) begin : track_responses
		rsp_t want;
		rsp_t got;
		if (arst_n && req_ch.valid && req_ch.ready) begin
			expected_rsp = {expected_rsp,
				predict_request(req_ch.cmd, req_ch.class_id, req_ch.value)};
			requests_taken++;
		end
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got.status       = rsp_ch.status;
			got.served_class = rsp_ch.served_class;
			got.served_value = rsp_ch.served_value;
			if (expected_rsp.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_SHOWN)
					$display("%0t: response with no request pending: status %0d class %0d value %h",
						$time, got.status, got.served_class, got.served_value);
			end else begin
				want = expected_rsp.pop_front();
				case (want.status)
					gcf_pkg::ST_ENQ:    n_enqueued++;
					gcf_pkg::ST_SERVED: n_served++;
					gcf_pkg::ST_EMPTY:  n_empty++;
					default:            n_dropped++;
				endcase
				if (got.status !== want.status || got.served_class !== want.served_class ||
					got.served_value !== want.served_value) begin
					mismatches++;
					if (mismatches <= MAX_SHOWN)
						$display("%0t: mismatch: status %0d/%0d class %0d/%0d value %h/%h (exp/got)",
							$time, want.status, got.status, want.served_class, got.served_class,
							want.served_value, got.served_value);
				end
			end
		end
	end

	// Watchdog: end a hung run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d responses outstanding", $time, expected_rsp.size());
			$display("FAIL grouped_class_fifo");
			$finish;
		end
	end

	// Send one request: idle at random, then hold valid until accepted.
	task automatic send_request(input logic [gcf_pkg::CMD_W-1:0] op,
		input logic [gcf_pkg::CLASS_ID_W-1:0] cid, input logic [gcf_pkg::VALUE_BITS-1:0] val);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid    <= 1'b1;
		req_ch.cmd      <= op;
		req_ch.class_id <= cid;
		req_ch.value    <= val;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
	endtask

	// Dequeue before anything was enqueued; junk in the ignored fields.
	task automatic test_empty_dequeue();
		send_request(gcf_pkg::CMD_DEQ, 3'd7, 16'hFFFF);
	endtask

	// Enqueue into class ids outside 1..4: drop each one.
	task automatic test_bad_class();
		send_request(gcf_pkg::CMD_ENQ, 3'd0, 16'h1234);
		send_request(gcf_pkg::CMD_ENQ, 3'd5, 16'hFFFF);
		send_request(gcf_pkg::CMD_ENQ, 3'd7, 16'h0000);
	endtask

	// Class 2 arrives first and must be fully served before class 1.
	task automatic test_service_order();
		send_request(gcf_pkg::CMD_ENQ, 3'd2, 16'hFFFF);
		send_request(gcf_pkg::CMD_ENQ, 3'd1, 16'h0000);
		send_request(gcf_pkg::CMD_ENQ, 3'd2, 16'h0001);
		send_request(gcf_pkg::CMD_DEQ, 3'd0, 16'h0000);
		send_request(gcf_pkg::CMD_DEQ, 3'd4, 16'hAAAA);
	endtask

	// Class 1 holds one value already: top it up to the depth, then
	// overflow it once with a walking one.
	task automatic test_class_full();
		for (int i = 0; i < gcf_pkg::CLASS_DEPTH; i++)
			send_request(gcf_pkg::CMD_ENQ, 3'd1, gcf_pkg::VALUE_BITS'(1) << i);
	endtask

	// Random traffic in bursts; each burst leans toward dequeue, stays even
	// or leans toward enqueue, and favors one class so classes reach both full and empty.
	task automatic run_mixed_traffic(input int count);
		int enq_pct;
		int burst_left;
		int favored;
		logic [gcf_pkg::CLASS_ID_W-1:0] cid;
		logic [gcf_pkg::VALUE_BITS-1:0] val;
		burst_left = 0;
		enq_pct    = 50;
		favored    = 1;
		repeat (count) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(60, 15);
				case ($urandom_range(2))
					0:       enq_pct = 20;
					1:       enq_pct = 50;
					default: enq_pct = 85;
				endcase
				favored = $urandom_range(gcf_pkg::NUM_CLASSES, 1);
			end
			burst_left--;
			case ($urandom_range(9))
				0:       val = '0;
				1:       val = '1;
				default: val = gcf_pkg::VALUE_BITS'($urandom);
			endcase
			if ($urandom_range(99) < 4) begin
				// out-of-range class, always dropped
				case ($urandom_range(3))
					0:       cid = 3'd0;
					1:       cid = 3'd5;
					2:       cid = 3'd6;
					default: cid = 3'd7;
				endcase
				send_request(gcf_pkg::CMD_ENQ, cid, val);
			end else if ($urandom_range(99) < enq_pct) begin
				if ($urandom_range(1) == 1)
					cid = gcf_pkg::CLASS_ID_W'(favored);
				else
					cid = gcf_pkg::CLASS_ID_W'($urandom_range(gcf_pkg::NUM_CLASSES, 1));
				send_request(gcf_pkg::CMD_ENQ, cid, val);
			end else begin
				send_request(gcf_pkg::CMD_DEQ, gcf_pkg::CLASS_ID_W'($urandom), val);
			end
		end
	endtask

	initial begin
		for (int i = 0; i < gcf_pkg::NUM_CLASSES; i++) begin
			rd_slot[i]   = '0;
			wr_slot[i]   = '0;
			fill[i]      = '0;
			turn_ring[i] = '0;
		end
		turn_head       = '0;
		turn_count      = '0;
		mismatches      = 0;
		requests_taken  = 0;
		n_enqueued      = 0;
		n_served        = 0;
		n_empty         = 0;
		n_dropped       = 0;
		cycle_count     = 0;
		req_ch.valid    = 1'b0;
		req_ch.cmd      = gcf_pkg::CMD_ENQ;
		req_ch.class_id = '0;
		req_ch.value    = '0;
		rsp_ch.ready    = 1'b0;

		// sender idles lightly, receiver stalls heavily
		send_idle_pct = 22;
		stall_pct     = 59;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_empty_dequeue();
		test_bad_class();
		test_service_order();
		test_class_full();
		run_mixed_traffic(300);

		// swap the pressure: sender idles heavily, receiver lightly
		send_idle_pct = 59;
		stall_pct     = 22;
		run_mixed_traffic(300);

		// back to back, no idling on either side
		send_idle_pct = 0;
		stall_pct     = 0;
		run_mixed_traffic(300);

		@(negedge clk);
		req_ch.valid <= 1'b0;

		// drain outstanding responses, then watch for strays
		while (expected_rsp.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("Covered %0d requests under three idle mixes: %0d enqueued, %0d served,",
			requests_taken, n_enqueued, n_served);
		$display("%0d dequeues on empty, %0d dropped; %0d mismatches",
			n_empty, n_dropped, mismatches);
		if (mismatches == 0 && expected_rsp.size() == 0)
			$display("PASS grouped_class_fifo");
		else
			$display("FAIL grouped_class_fifo");
		$finish;
	end

endmodule
